@@ src/clt_pkg.sv @@
package clt_pkg;

  // Nesting and argument count limits
  localparam int unsigned    NEST_MAX  = 255;
  localparam int unsigned    DEPTH_W   = $clog2(NEST_MAX + 1);
  localparam longint unsigned COUNT_MAX = 64'd65535;
  localparam int unsigned    COUNT_W   = $clog2(COUNT_MAX + 1);

  // Character codes
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Line status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_CMT_OPEN   = 3'd1;
  localparam logic [2:0] ST_XTRA_BRACE = 3'd2;
  localparam logic [2:0] ST_XTRA_PAREN = 3'd3;
  localparam logic [2:0] ST_UNCLOSED   = 3'd4;
  localparam logic [2:0] ST_OVERFLOW   = 3'd5;

  typedef struct packed {
    logic [7:0] ch;
    logic       char_present;
    logic       line_end;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        char_valid;
    logic        arg_start;
    logic        line_done;
    logic [2:0]  status;
    logic [3:0]  unclosed_mask;
    logic [15:0] arg_count;
  } result_t;

  // Whitespace test: space, tab, LF, VT, FF, CR
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

@@ src/clt_comment.sv @@
module clt_comment
  import clt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  item_t      item,
  output logic       pass,
  output logic       open
);

  logic comment_quote, comment_pipe, comment_skip_next, in_comment;
  logic comment_quote_next, comment_pipe_next, comment_skip_next_next, in_comment_next;

  // Filter one byte through the comment tracker
  always_comb begin
    comment_quote_next     = comment_quote;
    comment_pipe_next      = comment_pipe;
    comment_skip_next_next = comment_skip_next;
    in_comment_next        = in_comment;
    pass                   = 1'b0;
    if (item.char_present) begin
      if (in_comment) begin
        if (item.ch == CH_LF) begin
          in_comment_next = 1'b0;
          pass            = 1'b1;
        end
      end else if (comment_skip_next) begin
        comment_skip_next_next = 1'b0;
        pass                   = 1'b1;
      end else begin
        pass = 1'b1;
        priority if (item.ch == CH_BSLASH) begin
          comment_skip_next_next = 1'b1;
        end else if (item.ch == CH_HASH) begin
          if (!(comment_pipe || comment_quote)) begin
            in_comment_next = 1'b1;
            pass            = 1'b0;
          end
        end else if (item.ch == CH_PIPE) begin
          comment_pipe_next = !comment_pipe;
        end else if (item.ch == CH_QUOTE) begin
          comment_quote_next = !comment_quote;
        end else begin
          pass = 1'b1;
        end
      end
    end
    open = comment_quote_next || comment_pipe_next;
  end

  // Advance on each request; clear at line end
  always_ff @(posedge clk) begin
    if (rst || (step && item.line_end)) begin
      comment_quote     <= 1'b0;
      comment_pipe      <= 1'b0;
      comment_skip_next <= 1'b0;
      in_comment        <= 1'b0;
    end else if (step) begin
      comment_quote     <= comment_quote_next;
      comment_pipe      <= comment_pipe_next;
      comment_skip_next <= comment_skip_next_next;
      in_comment        <= in_comment_next;
    end
  end

endmodule

@@ src/clt_token.sv @@
module clt_token
  import clt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  logic    pass,
  input  logic    cmt_open,
  output result_t result
);

  logic               token_quote, token_pipe, token_escape, inside_argument;
  logic [DEPTH_W-1:0] brace_depth, paren_depth;
  logic [2:0]         early_error;
  logic [COUNT_W-1:0] argument_total;

  logic               token_quote_next, token_pipe_next, token_escape_next;
  logic               inside_argument_next;
  logic [DEPTH_W-1:0] brace_depth_next, paren_depth_next;
  logic [2:0]         early_error_next;
  logic [COUNT_W-1:0] argument_total_next;

  logic       emit, start;
  logic [3:0] mask;
  logic [7:0] c;

  assign c = item.ch;

  // Split, track groups and count arguments
  always_comb begin
    token_quote_next     = token_quote;
    token_pipe_next      = token_pipe;
    token_escape_next    = token_escape;
    inside_argument_next = inside_argument;
    brace_depth_next     = brace_depth;
    paren_depth_next     = paren_depth;
    early_error_next     = early_error;
    argument_total_next  = argument_total;
    emit                 = 1'b0;
    start                = 1'b0;
    if (item.char_present && pass && (early_error == ST_OK)) begin
      if (is_blank(c) && !token_quote && !token_pipe &&
          (brace_depth == '0) && (paren_depth == '0)) begin
        inside_argument_next = 1'b0;
      end else begin
        emit = 1'b1;
        if (!inside_argument) begin
          inside_argument_next = 1'b1;
          start                = 1'b1;
          if (argument_total != COUNT_W'(COUNT_MAX)) begin
            argument_total_next = argument_total + 1'b1;
          end
        end
        priority if (token_escape) begin
          token_escape_next = 1'b0;
        end else if (c == CH_BSLASH) begin
          token_escape_next = 1'b1;
        end else if (c == CH_QUOTE) begin
          token_quote_next = !token_quote;
        end else if (c == CH_PIPE) begin
          token_pipe_next = !token_pipe;
        end else if (!token_pipe) begin
          priority if (c == CH_LBRACE) begin
            if (brace_depth == DEPTH_W'(NEST_MAX)) early_error_next = ST_OVERFLOW;
            else brace_depth_next = brace_depth + 1'b1;
          end else if (c == CH_RBRACE) begin
            if (brace_depth == '0) early_error_next = ST_XTRA_BRACE;
            else brace_depth_next = brace_depth - 1'b1;
          end else if (c == CH_LPAREN) begin
            if (paren_depth == DEPTH_W'(NEST_MAX)) early_error_next = ST_OVERFLOW;
            else paren_depth_next = paren_depth + 1'b1;
          end else if (c == CH_RPAREN) begin
            if (paren_depth == '0) early_error_next = ST_XTRA_PAREN;
            else paren_depth_next = paren_depth - 1'b1;
          end else begin
            early_error_next = early_error;
          end
        end else begin
          early_error_next = early_error;
        end
      end
    end
  end

  // Build the result, with line status on the line end
  always_comb begin
    mask = {token_pipe_next, (paren_depth_next != '0), (brace_depth_next != '0),
            token_quote_next};
    result               = '0;
    result.out_char      = emit ? c : 8'h00;
    result.char_valid    = emit;
    result.arg_start     = emit && start;
    result.line_done     = item.line_end;
    if (item.line_end) begin
      priority if (cmt_open) begin
        result.status = ST_CMT_OPEN;
      end else if (early_error_next != ST_OK) begin
        result.status = early_error_next;
      end else if (mask != 4'b0000) begin
        result.status        = ST_UNCLOSED;
        result.unclosed_mask = mask;
      end else begin
        result.arg_count = 16'(argument_total_next);
      end
    end
  end

  // Advance on each request; clear at line end
  always_ff @(posedge clk) begin
    if (rst || (step && item.line_end)) begin
      token_quote     <= 1'b0;
      token_pipe      <= 1'b0;
      token_escape    <= 1'b0;
      inside_argument <= 1'b0;
      brace_depth     <= '0;
      paren_depth     <= '0;
      early_error     <= ST_OK;
      argument_total  <= '0;
    end else if (step) begin
      token_quote     <= token_quote_next;
      token_pipe      <= token_pipe_next;
      token_escape    <= token_escape_next;
      inside_argument <= inside_argument_next;
      brace_depth     <= brace_depth_next;
      paren_depth     <= paren_depth_next;
      early_error     <= early_error_next;
      argument_total  <= argument_total_next;
    end
  end

endmodule

@@ src/command_line_tokenizer.sv @@
// Channel  | Direction | Handshake                   | Payload
// item     | in        | item_valid / item_stall     | item_t (ch, char_present, line_end)
// result   | out       | result_valid / result_stall | result_t (one per request)
//
// One byte per cycle sustained while the result is not stalled. A request taken
// into the input register moves into the result register once that register can
// take it, and its result is then offered.
// The comment and tokenizer state advance as a request moves from the input
// register into the result register; all of it clears after a line end.
// Reset (rst, synchronous) empties both registers and clears all line state.
// A stalled result holds; the input register takes a request whenever it is
// empty or its request moves into the result register at the same edge.
module command_line_tokenizer
  import clt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic    s1_valid;
  item_t   s1_item;
  logic    load;
  logic    pass, cmt_open;
  result_t next_result;

  // Move the held request forward when the result register can take it
  assign load       = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !load;

  clt_comment u_comment (
    .clk  (clk),
    .rst  (rst),
    .step (load),
    .item (s1_item),
    .pass (pass),
    .open (cmt_open)
  );

  clt_token u_token (
    .clk      (clk),
    .rst      (rst),
    .step     (load),
    .item     (s1_item),
    .pass     (pass),
    .cmt_open (cmt_open),
    .result   (next_result)
  );

  // Capture a request
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      s1_item <= item;
    end
  end

  // Hold or replace the result
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= next_result;
    end
  end

endmodule
